// ----- src/kcmt_pkg.sv -----
// Shared constants and types for the keyed choice memo table.
`default_nettype none

package kcmt_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned ChoiceW  = 4;
  localparam int unsigned StatusW  = 2;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic [StatusW-1:0] STATUS_NONE     = 2'd0;
  localparam logic [StatusW-1:0] STATUS_UPDATED  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_APPENDED = 2'd2;
  localparam logic [StatusW-1:0] STATUS_DROPPED  = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [ChoiceW-1:0] choice;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ----- src/kcmt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module kcmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire              clk_i,
  input  wire              wr_en_i,
  input  wire  [AddrW-1:0] wr_addr_i,
  input  wire  [Width-1:0] wr_data_i,
  input  wire              rd_en_i,
  input  wire  [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- src/kcmt_ctrl.sv -----
// Scan sequencer: streams entries out of the RAM, compares keys, writes back.
`default_nettype none

module kcmt_ctrl #(
  parameter int unsigned Capacity = kcmt_pkg::CAPACITY,
  localparam int unsigned IdxW  = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CntW  = $clog2(Capacity + 1),
  localparam int unsigned DataW = kcmt_pkg::KeyW + kcmt_pkg::ChoiceW
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            mode_i,
  input  wire  [kcmt_pkg::KeyW-1:0]      key_i,
  input  wire  [kcmt_pkg::ChoiceW-1:0]   choice_in_i,
  output logic                           res_valid_o,
  input  wire                            res_ready_i,
  output kcmt_pkg::result_t              res_o,
  output logic                           rd_en_o,
  output logic [IdxW-1:0]                rd_addr_o,
  input  wire  [DataW-1:0]               rd_data_i,
  output logic                           wr_en_o,
  output logic [IdxW-1:0]                wr_addr_o,
  output logic [DataW-1:0]               wr_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic                           mode_q, mode_d;
  logic [kcmt_pkg::KeyW-1:0]      key_q, key_d;
  logic [kcmt_pkg::ChoiceW-1:0]   choice_q, choice_d;
  logic [CntW-1:0]                rd_idx_q, rd_idx_d;
  logic                           cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]                cmp_idx_q, cmp_idx_d;
  logic [CntW-1:0]                fill_q, fill_d;
  kcmt_pkg::result_t              res_q, res_d;
  logic                           wr_q, wr_d;
  logic                           app_q, app_d;
  logic [IdxW-1:0]                wr_addr_q, wr_addr_d;

  logic                           full;
  logic                           accept;
  logic                           match;
  logic                           last;
  logic                           miss_mode;
  kcmt_pkg::result_t              miss_res;
  logic                           miss_app;
  logic [kcmt_pkg::KeyW-1:0]      rd_key;
  logic [kcmt_pkg::ChoiceW-1:0]   rd_choice;

  assign full       = (fill_q == CntW'(Capacity));
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign rd_key    = rd_data_i[DataW-1:kcmt_pkg::ChoiceW];
  assign rd_choice = rd_data_i[kcmt_pkg::ChoiceW-1:0];

  // One read issued per cycle; data for the entry issued last cycle is compared now.
  assign rd_en_o   = (state_q == ST_SCAN) && (rd_idx_q != fill_q);
  assign rd_addr_o = rd_idx_q[IdxW-1:0];
  assign match     = cmp_valid_q && (rd_key == key_q);
  assign last      = cmp_valid_q && (rd_idx_q == fill_q);

  // Outcome when no stored key matches
  assign miss_mode = (state_q == ST_IDLE) ? mode_i : mode_q;
  always_comb begin
    miss_res.hit    = 1'b0;
    miss_res.choice = '0;
    miss_app        = 1'b0;
    priority if (miss_mode == kcmt_pkg::MODE_LOOKUP) begin
      miss_res.status = kcmt_pkg::STATUS_NONE;
    end else if (full) begin
      miss_res.status = kcmt_pkg::STATUS_DROPPED;
    end else begin
      miss_res.status = kcmt_pkg::STATUS_APPENDED;
      miss_app        = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    choice_d    = choice_q;
    rd_idx_d    = rd_idx_q;
    cmp_valid_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    fill_d      = fill_q;
    res_d       = res_q;
    wr_d        = wr_q;
    app_d       = app_q;
    wr_addr_d   = wr_addr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d   = mode_i;
          key_d    = key_i;
          choice_d = choice_in_i;
          rd_idx_d = '0;
          if (fill_q == '0) begin
            state_d   = ST_DONE;
            res_d     = miss_res;
            wr_d      = miss_app;
            app_d     = miss_app;
            wr_addr_d = fill_q[IdxW-1:0];
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en_o) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        cmp_valid_d = rd_en_o;
        cmp_idx_d   = rd_addr_o;
        priority if (match) begin
          state_d   = ST_DONE;
          app_d     = 1'b0;
          wr_addr_d = cmp_idx_q;
          if (mode_q == kcmt_pkg::MODE_LOOKUP) begin
            res_d.hit    = 1'b1;
            res_d.choice = rd_choice;
            res_d.status = kcmt_pkg::STATUS_NONE;
            wr_d         = 1'b0;
          end else begin
            res_d.hit    = 1'b0;
            res_d.choice = '0;
            res_d.status = kcmt_pkg::STATUS_UPDATED;
            wr_d         = 1'b1;
          end
        end else if (last) begin
          state_d     = ST_DONE;
          cmp_valid_d = 1'b0;
          res_d       = miss_res;
          wr_d        = miss_app;
          app_d       = miss_app;
          wr_addr_d   = fill_q[IdxW-1:0];
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
          if (app_q) begin
            fill_d = fill_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Write-back happens as the result leaves, so the next scan sees it.
  assign wr_en_o     = (state_q == ST_DONE) && res_ready_i && wr_q;
  assign wr_addr_o   = wr_addr_q;
  assign wr_data_o   = {key_q, choice_q};
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_valid_q <= 1'b0;
      fill_q      <= '0;
      wr_q        <= 1'b0;
      app_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= cmp_valid_d;
      fill_q      <= fill_d;
      wr_q        <= wr_d;
      app_q       <= app_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    choice_q  <= choice_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    wr_addr_q <= wr_addr_d;
  end

endmodule

`default_nettype wire

// ----- src/keyed_choice_memo_table.sv -----
// Top level of the keyed choice memo table: RAM, scan sequencer, output register.
//
//  channel | valid/ready          | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid_i/in_ready_o | mode_i, key_i, choice_in_i
//  out     | out_valid_o/out_ready_i | hit_o, choice_out_o, insert_status_o
//
// One item at a time. A beat that finds its key at entry k ends the scan there;
// a miss scans every filled entry, and a beat on an empty table skips the scan.
// The scan is paced by the single RAM read port, one entry per cycle.
// Reset empties the table (fill count to zero); the RAM itself is not cleared.
// A stalled output holds its beat while the next input beat is taken and scanned.
`default_nettype none

module keyed_choice_memo_table #(
  parameter int unsigned Capacity = kcmt_pkg::CAPACITY
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            mode_i,
  input  wire  [kcmt_pkg::KeyW-1:0]      key_i,
  input  wire  [kcmt_pkg::ChoiceW-1:0]   choice_in_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           hit_o,
  output logic [kcmt_pkg::ChoiceW-1:0]   choice_out_o,
  output logic [kcmt_pkg::StatusW-1:0]   insert_status_o
);

  localparam int unsigned IdxW  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned DataW = kcmt_pkg::KeyW + kcmt_pkg::ChoiceW;

  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic [DataW-1:0]  rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [DataW-1:0]  wr_data;
  logic              res_valid;
  logic              res_ready;
  kcmt_pkg::result_t res;
  kcmt_pkg::result_t out_q;
  logic              out_valid_q;

  kcmt_ram #(
    .Width (DataW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  kcmt_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .choice_in_i (choice_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign choice_out_o    = out_q.choice;
  assign insert_status_o = out_q.status;

endmodule

`default_nettype wire

// ----- src/kcmt_chk.sv -----
// Port-level checker for the keyed choice memo table, bound to the top level.
`default_nettype none

module kcmt_chk (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_o,
  input wire                            out_valid_o,
  input wire                            out_ready_i,
  input wire                            hit_o,
  input wire [kcmt_pkg::ChoiceW-1:0]    choice_out_o,
  input wire [kcmt_pkg::StatusW-1:0]    insert_status_o
);

  // Held result beat must not change under backpressure
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o)
      && $stable(choice_out_o) && $stable(insert_status_o))
    else $error("output beat changed while stalled");

  // A taken input beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after a beat");

  a_hit_is_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> insert_status_o == kcmt_pkg::STATUS_NONE)
    else $error("hit reported on an insert");

  a_choice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> choice_out_o == '0)
    else $error("choice returned without a hit");

endmodule

bind keyed_choice_memo_table kcmt_chk u_kcmt_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .choice_out_o    (choice_out_o),
  .insert_status_o (insert_status_o)
);

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking bench for the keyed choice memo table: directed and random traffic against a table predictor.
`default_nettype none

module testbench;
  import kcmt_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = CAPACITY + 12;
  localparam int unsigned RandomItems = 1535;

  typedef struct {
    logic               mode;
    logic [KeyW-1:0]    key;
    logic [ChoiceW-1:0] choice;
    int unsigned        gap;
  } req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_mode = MODE_LOOKUP;
  logic [KeyW-1:0]    req_key = '0;
  logic [ChoiceW-1:0] req_choice = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               res_hit;
  logic [ChoiceW-1:0] res_choice;
  logic [StatusW-1:0] res_status;

  req_t               pending_reqs[$];
  result_t            expected_results[$];
  logic [KeyW-1:0]    known_keys[$];

  // Predicted table contents
  logic [KeyW-1:0]    memo_keys[CAPACITY];
  logic [ChoiceW-1:0] memo_choices[CAPACITY];
  int unsigned        memo_fill = 0;

  int unsigned        cycles = 0;
  int unsigned        errors = 0;
  int unsigned        results_seen = 0;
  int unsigned        wait_cnt = 0;
  int unsigned        stall_left = 0;
  logic               in_took = 1'b0;
  logic               out_took = 1'b0;

  keyed_choice_memo_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (req_mode),
    .key_i          (req_key),
    .choice_in_i    (req_choice),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hit_o          (res_hit),
    .choice_out_o   (res_choice),
    .insert_status_o(res_status)
  );

  always #4 clk_i = ~clk_i;

  function automatic result_t memo_access(input logic mode, input logic [KeyW-1:0] key,
                                          input logic [ChoiceW-1:0] choice);
    result_t r;
    int      pos;
    r   = '0;
    pos = -1;
    for (int i = 0; i < memo_fill; i++) begin
      if (pos < 0 && memo_keys[i] == key) pos = i;
    end
    if (mode == MODE_LOOKUP) begin
      r.status = STATUS_NONE;
      if (pos >= 0) begin
        r.hit    = 1'b1;
        r.choice = memo_choices[pos];
      end
    end else if (pos >= 0) begin
      memo_choices[pos] = choice;
      r.status = STATUS_UPDATED;
    end else if (memo_fill < CAPACITY) begin
      memo_keys[memo_fill]    = key;
      memo_choices[memo_fill] = choice;
      memo_fill++;
      r.status = STATUS_APPENDED;
    end else begin
      r.status = STATUS_DROPPED;
    end
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic queue_req(input logic mode, input logic [KeyW-1:0] key,
                           input logic [ChoiceW-1:0] choice);
    req_t r;
    r.mode   = mode;
    r.key    = key;
    r.choice = choice;
    // every 250 items, a stretch of 50 back-to-back beats
    r.gap    = ((pending_reqs.size() % 250) >= 200) ? 0 : $urandom_range(0, 14);
    pending_reqs.push_back(r);
    if (mode == MODE_INSERT) known_keys.push_back(key);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KeyW-1:0] pick_known();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Driver: payload changes on the falling edge only
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (wait_cnt < pending_reqs[0].gap) begin
          in_valid <= 1'b0;
          wait_cnt <= wait_cnt + 1;
        end else begin
          in_valid   <= 1'b1;
          req_mode   <= pending_reqs[0].mode;
          req_key    <= pending_reqs[0].key;
          req_choice <= pending_reqs[0].choice;
          wait_cnt   <= 0;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // Output back-pressure: stall drawn after each result beat
  always @(negedge clk_i) begin : stall_gen
    int unsigned n;
    if (rst_ni) begin
      if (out_took) begin
        n = ((results_seen % 250) >= 200) ? 0 : $urandom_range(0, 14);
        stall_left <= n;
        out_ready  <= (n == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end
    end
  end

  // Monitor: checks result beats, then predicts the input beat taken on this edge
  always @(posedge clk_i) begin : monitor
    result_t want;
    in_took  <= rst_ni && in_valid && in_ready;
    out_took <= rst_ni && out_valid && out_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report("result beat with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (res_hit !== want.hit)
            report($sformatf("hit %b, want %b", res_hit, want.hit));
          if (res_choice !== want.choice)
            report($sformatf("choice_out %h, want %h", res_choice, want.choice));
          if (res_status !== want.status)
            report($sformatf("insert_status %0d, want %0d", res_status, want.status));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(memo_access(req_mode, req_key, req_choice));
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("keyed_choice_memo_table: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KeyW-1:0] k;
    int unsigned     pick;

    // directed: empty table, extreme keys, update, one-bit neighbours
    queue_req(MODE_LOOKUP, '0, 4'h0);
    queue_req(MODE_INSERT, '0, 4'h0);
    queue_req(MODE_INSERT, '1, 4'hF);
    queue_req(MODE_LOOKUP, '0, 4'hF);
    queue_req(MODE_LOOKUP, '1, 4'h0);
    queue_req(MODE_LOOKUP, 64'd1, 4'h0);
    queue_req(MODE_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 4'h0);
    queue_req(MODE_INSERT, '0, 4'hA);
    queue_req(MODE_LOOKUP, '0, 4'h0);
    queue_req(MODE_INSERT, 64'd1, 4'h5);
    queue_req(MODE_INSERT, 64'h8000_0000_0000_0000, 4'h3);
    queue_req(MODE_LOOKUP, 64'h8000_0000_0000_0000, 4'h0);
    queue_req(MODE_LOOKUP, '1, 4'h7);
    queue_req(MODE_INSERT, '1, 4'h0);
    queue_req(MODE_LOOKUP, '1, 4'hC);
    queue_req(MODE_LOOKUP, 64'd1, 4'h0);
    queue_req(MODE_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 4'h9);
    queue_req(MODE_LOOKUP, 64'hA5A5_5A5A_0F0F_F0F1, 4'h0);
    queue_req(MODE_LOOKUP, 64'hA5A5_5A5A_0F0F_F0F0, 4'h0);

    // random: mostly known keys so hits and updates dominate; the table fills
    // early, after which new-key inserts are dropped
    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_req(MODE_LOOKUP, pick_known(), 4'($urandom));
      end else if (pick < 45) begin
        queue_req(MODE_LOOKUP, rand_key(), 4'($urandom));
      end else if (pick < 55) begin
        k = pick_known() ^ (64'd1 << $urandom_range(0, 63));
        queue_req(MODE_LOOKUP, k, 4'($urandom));
      end else if (pick < 78) begin
        queue_req(MODE_INSERT, rand_key(), 4'($urandom));
      end else if (pick < 93) begin
        queue_req(MODE_INSERT, pick_known(), 4'($urandom));
      end else begin
        k = pick_known() ^ (64'd1 << $urandom_range(0, 63));
        queue_req(MODE_INSERT, k, 4'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("keyed_choice_memo_table: match");
    end else begin
      $display("keyed_choice_memo_table: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- keyed_choice_memo_table.f -----
src/kcmt_pkg.sv
src/kcmt_ram.sv
src/kcmt_ctrl.sv
src/keyed_choice_memo_table.sv
src/kcmt_chk.sv
test/testbench.sv
